/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define EVH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define EVH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/evh_pkg.sv */
// Shared constants, types and helpers of the event handler slot table.
package evh_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int OP_W       = 3;
  localparam int ID_W       = 16;
  localparam int TOK_W      = 32;
  localparam int ST_W       = 2;
  localparam int SIDX_W     = 4;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  localparam logic [OP_W-1:0] OP_ADD           = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_UNTOUCHED = 3'd1;
  localparam logic [OP_W-1:0] OP_DISPATCH      = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR         = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET         = 3'd4;

  localparam logic [ST_W-1:0] ST_SUCCESS    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL       = 2'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN    = 2'd2;
  localparam logic [ST_W-1:0] ST_DISPATCHED = 2'd3;

  typedef struct packed {
    logic capture;
    logic execute;
  } evh_cmd_t;

  function automatic logic [SIDX_W-1:0] slot_low4(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SIDX_W-1:0] ext;
    ext = {{SIDX_W{1'b0}}, idx};
    return ext[SIDX_W-1:0];
  endfunction

endpackage

/* rtl/evh_ctrl.sv */
// Controller state machine: input handshake, execute step, result handshake.
module evh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output evh_pkg::evh_cmd_t cmd
);
  import evh_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_fire;

  assign in_tready   = (state_r == S_IDLE) || ((state_r == S_OUT) && out_tready);
  assign in_fire     = in_tvalid && in_tready;
  assign out_tvalid  = (state_r == S_OUT);
  assign cmd.capture = in_fire;
  assign cmd.execute = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = in_fire ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/evh_datapath.sv */
// Datapath: input register, slot table, match and free-slot search, result register.
module evh_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  evh_pkg::evh_cmd_t                 cmd,
  input  logic [evh_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [evh_pkg::OP_W-1:0]          in_tuser,
  output logic [evh_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [evh_pkg::ST_W-1:0]          out_tuser
);
  import evh_pkg::*;

  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [TOK_W-1:0]  tok_r;
  logic              keep_r;

  logic [SLOT_COUNT-1:0] used_r;
  logic [SLOT_COUNT-1:0] used_nxt;
  logic [SLOT_COUNT-1:0] pers_r;
  logic [SLOT_COUNT-1:0] pers_nxt;
  logic [SLOT_COUNT-1:0] touched_r;
  logic [ID_W-1:0]       slot_id_r  [SLOT_COUNT];
  logic [TOK_W-1:0]      slot_tok_r [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] hit;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic                  match_found;
  logic [IDX_W-1:0]      match_idx;
  logic                  do_write;
  logic [TOK_W-1:0]      wr_tok;
  logic                  wr_keep;

  logic [ST_W-1:0]   status_r;
  logic [ST_W-1:0]   status_nxt;
  logic [TOK_W-1:0]  mtok_r;
  logic [TOK_W-1:0]  mtok_nxt;
  logic [SIDX_W-1:0] sidx_r;
  logic [SIDX_W-1:0] sidx_nxt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_r   <= in_tdata[ID_W-1:0];
      tok_r  <= in_tdata[ID_W+TOK_W-1:ID_W];
      keep_r <= in_tdata[ID_W+TOK_W];
      op_r   <= in_tuser;
    end
  end

  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      hit[i] = used_r[i] && (slot_id_r[i] == id_r);
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (hit[i]) begin
        match_found = 1'b1;
        match_idx   = IDX_W'(i);
      end
    end
  end

  assign wr_tok   = (op_r == OP_ADD_UNTOUCHED) ? '0 : tok_r;
  assign wr_keep  = (op_r == OP_ADD_UNTOUCHED) ? 1'b0 : keep_r;
  assign do_write = cmd.execute && free_found &&
                    ((op_r == OP_ADD) || (op_r == OP_ADD_UNTOUCHED));

  always_comb begin
    used_nxt   = used_r;
    pers_nxt   = pers_r;
    status_nxt = ST_SUCCESS;
    mtok_nxt   = '0;
    sidx_nxt   = '0;
    case (op_r) inside
      OP_ADD, OP_ADD_UNTOUCHED: begin
        if (free_found) begin
          used_nxt[free_idx] = 1'b1;
          pers_nxt[free_idx] = wr_keep;
          sidx_nxt           = slot_low4(free_idx);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      OP_DISPATCH: begin
        if (match_found) begin
          used_nxt = used_r & pers_r;
          sidx_nxt = slot_low4(match_idx);
          if (touched_r[match_idx]) begin
            status_nxt = ST_DISPATCHED;
            mtok_nxt   = slot_tok_r[match_idx];
          end
        end else begin
          status_nxt = ST_UNKNOWN;
        end
      end
      OP_CLEAR: begin
        used_nxt = used_r & pers_r;
      end
      OP_RESET: begin
        used_nxt = '0;
        pers_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      pers_r <= '0;
    end else if (cmd.execute) begin
      used_r <= used_nxt;
      pers_r <= pers_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      touched_r[free_idx]  <= (wr_tok != '0);
      slot_id_r[free_idx]  <= id_r;
      slot_tok_r[free_idx] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r <= status_nxt;
      mtok_r   <= mtok_nxt;
      sidx_r   <= sidx_nxt;
    end
  end

  assign out_tdata = {{(OUT_DATA_W - TOK_W - SIDX_W){1'b0}}, sidx_r, mtok_r};
  assign out_tuser = status_r;

endmodule

/* rtl/event_handler_slot_table.sv */
// Event handler slot table: top level joining controller and datapath.
//
// Input channel (in_*): one transaction carries one operation in in_tuser
// (add, add untouched, dispatch, clear, reset) with event id, handler token
// and persistent flag in in_tdata. Result channel (out_*): one transaction
// per operation, status in out_tuser, matched token and slot in out_tdata.
// After the input transaction the controller passes through its execute
// state, then raises out_tvalid in its result state. No input is taken in
// the execute state; an operation runs through the input register, the
// execute step over the slot table and the result register. The next input
// is taken in the same cycle the pending result is taken. A stalled sink
// holds the result and blocks input.
// Reset (rst_n low, synchronous) frees all slots and drops any pending
// result; event ids and tokens are not cleared and are only read for slots
// marked used.
module event_handler_slot_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] event_id, [47:16] handler_token, [48] persistent, [55:49] zero
  input  logic [evh_pkg::IN_DATA_W-1:0]     in_tdata,
  // [2:0] operation
  input  logic [evh_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] matched_token, [35:32] slot_index, [39:36] zero
  output logic [evh_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [evh_pkg::ST_W-1:0]          out_tuser
);
  import evh_pkg::*;

  evh_cmd_t cmd;

  evh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  evh_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

/* rtl/evh_checker.sv */
// Port-level checker of the event handler slot table and its bind.
`include "assert_macros.svh"

module evh_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [evh_pkg::IN_DATA_W-1:0]     in_tdata,
  input logic [evh_pkg::OP_W-1:0]          in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [evh_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic [evh_pkg::ST_W-1:0]          out_tuser
);
  import evh_pkg::*;

  `EVH_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed under stall")

  `EVH_ASSERT_NOW(a_token_only_dispatched, out_tvalid && (out_tuser != ST_DISPATCHED),
    out_tdata[TOK_W-1:0] == '0, "token nonzero outside dispatch")

  `EVH_ASSERT_NOW(a_no_slot_on_fail,
    out_tvalid && ((out_tuser == ST_FULL) || (out_tuser == ST_UNKNOWN)),
    out_tdata[TOK_W+SIDX_W-1:TOK_W] == '0, "slot nonzero on failure")

  `EVH_ASSERT_NEXT(a_accept_then_exec, in_tvalid && in_tready,
    !out_tvalid && !in_tready, "result or input taken during execute")

endmodule

bind event_handler_slot_table evh_checker u_evh_checker (.*);
